// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the chunked body decoder.
// Depends on nothing; synthesis builds define SYNTHESIS to drop the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHD_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
`define CHD_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");
`else
`define CHD_ASSERT(label, clk, rstn, prop)
`define CHD_NEVER(label, clk, rstn, cond)
`endif
`endif

// File: rtl/chd_pkg.sv
// Types and constants of the chunked body decoder.
// Used by chd_parser and http_chunked_body_decoder_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package chd_pkg;

    localparam int SIZE_W  = 33;
    localparam int LIMIT_W = 29;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1) << 28;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    typedef enum logic [3:0] {
        PH_START   = 4'd0,
        PH_HEX     = 4'd1,
        PH_HEX_CR  = 4'd2,
        PH_EXT     = 4'd3,
        PH_EXT_CR  = 4'd4,
        PH_DATA    = 4'd5,
        PH_DATA_CR = 4'd6,
        PH_DATA_LF = 4'd7,
        PH_DONE    = 4'd8,
        PH_ERROR   = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        ST_BUSY  = 2'd0,
        ST_DONE  = 2'd1,
        ST_ERROR = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       final_byte;
    } item_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        status_t    decode_status;
    } result_t;

endpackage
`default_nettype wire

// File: rtl/chd_parser.sv
// Parse state and one-byte update of the chunked body decoder.
// Depends on chd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module chd_parser (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          step_en,
    input  chd_pkg::item_t               item,
    input  wire  [chd_pkg::LIMIT_W-1:0]  max_chunk_size,
    output chd_pkg::result_t             result
);

    chd_pkg::phase_t               phase_reg, phase_next;
    logic [chd_pkg::SIZE_W-1:0]    size_reg, size_next;
    logic [chd_pkg::SIZE_W-1:0]    shifted;
    logic [chd_pkg::SIZE_W-1:0]    remaining;
    logic                          hex_ok;
    logic [3:0]                    hex_digit;
    logic [7:0]                    c;

    always_comb begin
        c         = item.body_byte;
        hex_ok    = 1'b1;
        hex_digit = 4'd0;
        if (c inside {[8'h30:8'h39]}) begin
            hex_digit = c[3:0];
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            hex_digit = c[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign shifted   = {size_reg[chd_pkg::SIZE_W-5:0], hex_digit};
    assign remaining = size_reg - chd_pkg::SIZE_W'(1);

    always_comb begin
        phase_next           = phase_reg;
        size_next            = size_reg;
        result.payload_valid = 1'b0;
        result.payload_byte  = 8'd0;
        case (phase_reg)
            chd_pkg::PH_START, chd_pkg::PH_HEX: begin
                if (c == chd_pkg::CH_CR) begin
                    phase_next = chd_pkg::PH_HEX_CR;
                end else if (c == chd_pkg::CH_SEMI) begin
                    phase_next = chd_pkg::PH_EXT;
                end else if (c == chd_pkg::CH_SPACE || c == chd_pkg::CH_TAB) begin
                    phase_next = chd_pkg::PH_HEX;
                end else if (!hex_ok) begin
                    phase_next = chd_pkg::PH_ERROR;
                end else begin
                    size_next  = shifted;
                    phase_next = (shifted > {4'd0, max_chunk_size}) ?
                                 chd_pkg::PH_ERROR : chd_pkg::PH_HEX;
                end
            end
            chd_pkg::PH_HEX_CR: begin
                if (c != chd_pkg::CH_LF) begin
                    phase_next = chd_pkg::PH_ERROR;
                end else begin
                    phase_next = (size_reg == '0) ? chd_pkg::PH_DONE : chd_pkg::PH_DATA;
                end
            end
            chd_pkg::PH_EXT: begin
                if (c == chd_pkg::CH_CR) begin
                    phase_next = chd_pkg::PH_EXT_CR;
                end
            end
            chd_pkg::PH_EXT_CR: begin
                // a lone CR inside an extension is simply skipped
                if (c == chd_pkg::CH_LF) begin
                    phase_next = (size_reg == '0) ? chd_pkg::PH_DONE : chd_pkg::PH_DATA;
                end else if (c != chd_pkg::CH_CR) begin
                    phase_next = chd_pkg::PH_EXT;
                end
            end
            chd_pkg::PH_DATA: begin
                result.payload_valid = 1'b1;
                result.payload_byte  = c;
                size_next            = remaining;
                if (remaining == '0) begin
                    phase_next = chd_pkg::PH_DATA_CR;
                end
            end
            chd_pkg::PH_DATA_CR: begin
                phase_next = (c == chd_pkg::CH_CR) ? chd_pkg::PH_DATA_LF : chd_pkg::PH_ERROR;
            end
            chd_pkg::PH_DATA_LF: begin
                if (c == chd_pkg::CH_LF) begin
                    phase_next = chd_pkg::PH_START;
                    size_next  = '0;
                end else begin
                    phase_next = chd_pkg::PH_ERROR;
                end
            end
            chd_pkg::PH_DONE: begin
                phase_next = chd_pkg::PH_DONE;
            end
            default: begin
                phase_next = chd_pkg::PH_ERROR;
            end
        endcase

        // end of input: clean only right after a chunk's closing CRLF
        if (item.final_byte && phase_next != chd_pkg::PH_DONE &&
            phase_next != chd_pkg::PH_ERROR) begin
            phase_next = (phase_next == chd_pkg::PH_START) ?
                         chd_pkg::PH_DONE : chd_pkg::PH_ERROR;
        end

        case (phase_next)
            chd_pkg::PH_DONE:  result.decode_status = chd_pkg::ST_DONE;
            chd_pkg::PH_ERROR: result.decode_status = chd_pkg::ST_ERROR;
            default:           result.decode_status = chd_pkg::ST_BUSY;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= chd_pkg::PH_START;
            size_reg  <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            size_reg  <= size_next;
        end
    end

    `CHD_ASSERT(a_done_sticky, aclk, aresetn,
        (phase_reg == chd_pkg::PH_DONE) |=> (phase_reg == chd_pkg::PH_DONE))
    `CHD_ASSERT(a_error_sticky, aclk, aresetn,
        (phase_reg == chd_pkg::PH_ERROR) |=> (phase_reg == chd_pkg::PH_ERROR))
    `CHD_NEVER(a_data_count_zero, aclk, aresetn,
        (phase_reg == chd_pkg::PH_DATA) && (size_reg == '0))
    `CHD_ASSERT(a_payload_in_data, aclk, aresetn,
        (step_en && result.payload_valid) |-> (phase_reg == chd_pkg::PH_DATA))

endmodule
`default_nettype wire

// File: rtl/http_chunked_body_decoder_top.sv
// Top level of the HTTP/1.1 chunked body decoder: stream ports, input
// register, limit register and result register. Depends on chd_pkg, chd_parser.
`timescale 1ns / 1ps
`default_nettype none
// Decodes an HTTP/1.1 chunked body one byte per request and returns one result
// per input byte: the payload byte with its valid flag in m_tuser, and the
// sticky status (in progress, complete, error). Throughput is one byte every
// cycle while m_tready keeps up; each byte passes the input register, then the
// result register, with the phase update and 33-bit size shift/compare or decrement
// done combinationally between them. The user must write the chunk size limit via
// cfg_valid/cfg_data (always ready) while no byte is in flight; the block does not check it.
module http_chunked_body_decoder_top (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         cfg_valid,
    output logic                        cfg_ready,
    input  wire  [chd_pkg::LIMIT_W-1:0] cfg_data,   // max_chunk_size
    input  wire                         s_tvalid,
    output logic                        s_tready,
    input  wire  [7:0]                  s_tdata,    // [7:0] body_byte
    input  wire                         s_tlast,    // final_byte
    output logic                        m_tvalid,
    input  wire                         m_tready,
    output logic [15:0]                 m_tdata,    // [7:0] payload_byte, [9:8] decode_status
    output logic                        m_tuser     // payload_valid
);

    logic [chd_pkg::LIMIT_W-1:0] limit_reg;
    chd_pkg::item_t              item_reg;
    logic                        in_valid_reg;
    chd_pkg::result_t            result;
    chd_pkg::result_t            out_reg;
    logic                        out_valid_reg;
    logic                        advance;

    assign cfg_ready = 1'b1;

    // move the held byte on whenever the result register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= chd_pkg::LIMIT_RESET;
        end else if (cfg_valid) begin
            limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.body_byte  <= s_tdata;
            item_reg.final_byte <= s_tlast;
        end
    end

    chd_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (advance),
        .item           (item_reg),
        .max_chunk_size (limit_reg),
        .result         (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.payload_valid;
    assign m_tdata  = {6'd0, out_reg.decode_status, out_reg.payload_byte};

    `CHD_ASSERT(a_hold_input, aclk, aresetn,
        (in_valid_reg && !advance) |=> in_valid_reg)
    `CHD_ASSERT(a_result_follows_step, aclk, aresetn,
        advance |=> out_valid_reg)
    `CHD_NEVER(a_idle_byte_nonzero, aclk, aresetn,
        out_valid_reg && !out_reg.payload_valid && (out_reg.payload_byte != 8'd0))

endmodule
`default_nettype wire

// File: sim/tb_http_chunked_body_decoder_top.sv
// Self-checking testbench for http_chunked_body_decoder_top: streams chunked bodies,
// predicts every result with its own decoder and compares field by field.
// Depends on chd_pkg and the RTL of the decoder only.
`timescale 1ns / 1ps
module tb_http_chunked_body_decoder_top;
    import chd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef enum int {
        END_ZERO_CHUNK,
        END_EMPTY_LINE,
        END_FINAL_ON_LF,
        END_TRUNCATED,
        END_BAD_HEX,
        END_OVER_LIMIT,
        END_NO_CRLF,
        END_LONE_CR,
        END_FINAL_IN_LINE,
        END_ZERO_LIMIT
    } ending_t;

    // Tracks the decoder state and holds the results still owed by the block.
    class chunk_decode_board;
        phase_t                phase;
        logic [SIZE_W-1:0]     remaining;
        logic [LIMIT_W-1:0]    limit;
        result_t               expected_results[$];
        int                    mismatches;

        function new();
            phase      = PH_START;
            remaining  = '0;
            limit      = LIMIT_RESET;
            mismatches = 0;
        endfunction

        function void close_line();
            phase = (remaining == '0) ? PH_DONE : PH_DATA;
        endfunction

        function void note_request(logic [7:0] c, logic last);
            result_t    r;
            logic [4:0] digit;
            r     = '0;
            digit = 5'h10;
            case (phase)
                PH_START, PH_HEX: begin
                    if (c == CH_CR) begin
                        phase = PH_HEX_CR;
                    end else if (c == CH_SEMI) begin
                        phase = PH_EXT;
                    end else if (c == CH_SPACE || c == CH_TAB) begin
                        phase = PH_HEX;
                    end else begin
                        if (c >= "0" && c <= "9") digit = 5'(c - "0");
                        else if (c >= "a" && c <= "f") digit = 5'(c - "a" + 10);
                        else if (c >= "A" && c <= "F") digit = 5'(c - "A" + 10);
                        if (digit[4]) begin
                            phase = PH_ERROR;
                        end else begin
                            remaining = {remaining[SIZE_W-5:0], digit[3:0]};
                            phase = (remaining > limit) ? PH_ERROR : PH_HEX;
                        end
                    end
                end
                PH_HEX_CR: begin
                    if (c == CH_LF) close_line();
                    else phase = PH_ERROR;
                end
                PH_EXT: begin
                    if (c == CH_CR) phase = PH_EXT_CR;
                end
                PH_EXT_CR: begin
                    // a lone CR inside an extension is simply skipped
                    if (c == CH_LF) close_line();
                    else if (c != CH_CR) phase = PH_EXT;
                end
                PH_DATA: begin
                    r.payload_valid = 1'b1;
                    r.payload_byte  = c;
                    remaining = remaining - 1'b1;
                    if (remaining == '0) phase = PH_DATA_CR;
                end
                PH_DATA_CR: begin
                    phase = (c == CH_CR) ? PH_DATA_LF : PH_ERROR;
                end
                PH_DATA_LF: begin
                    if (c == CH_LF) begin
                        phase     = PH_START;
                        remaining = '0;
                    end else begin
                        phase = PH_ERROR;
                    end
                end
                PH_DONE: ;
                default: phase = PH_ERROR;
            endcase
            // end of input is clean only straight after a chunk's CRLF
            if (last && phase != PH_DONE && phase != PH_ERROR)
                phase = (phase == PH_START) ? PH_DONE : PH_ERROR;
            if (phase == PH_DONE) r.decode_status = ST_DONE;
            else if (phase == PH_ERROR) r.decode_status = ST_ERROR;
            else r.decode_status = ST_BUSY;
            expected_results.push_back(r);
        endfunction

        function void check_result(logic valid, logic [15:0] data);
            result_t want;
            if (expected_results.size() == 0) begin
                $error("result arrived with no request outstanding");
                mismatches++;
                return;
            end
            want = expected_results.pop_front();
            if (want.payload_valid !== valid) begin
                $error("payload_valid: expected %0d, got %0d", want.payload_valid, valid);
                mismatches++;
            end
            if (want.payload_byte !== data[7:0]) begin
                $error("payload_byte: expected %0d, got %0d", want.payload_byte, data[7:0]);
                mismatches++;
            end
            if (want.decode_status !== data[9:8]) begin
                $error("decode_status: expected %0d, got %0d", want.decode_status, data[9:8]);
                mismatches++;
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [LIMIT_W-1:0]  cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [15:0]         m_tdata;
    logic                m_tuser;

    chunk_decode_board   board;
    int                  gap_pct;
    int                  stall_pct;
    int                  accepted_bytes;
    int                  cycle_count;

    http_chunked_body_decoder_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL http_chunked_body_decoder_top");
            $finish;
        end
    end

    // Result side: check on handshake, then decide whether to stall next cycle.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tuser, m_tdata);
        m_tready <= !(stall_pct != 0 && $urandom_range(0, 99) < stall_pct);
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        board.note_request(b, last);
        accepted_bytes++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    // Hold off the sender until every outstanding request has its result.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.limit = value;
    endtask

    // Size line with random case, blanks, leading zeros and an optional extension.
    task automatic send_size_line(input int unsigned value);
        int          nibbles;
        int          i;
        int unsigned nib;
        logic [7:0]  ch;
        nibbles = 1;
        while (nibbles < 8 && (value >> (4 * nibbles)) != 0) nibbles++;
        if ($urandom_range(0, 3) == 0) send_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
        if (board.limit != '0) repeat ($urandom_range(0, 2)) send_byte("0", 1'b0);
        for (i = nibbles - 1; i >= 0; i--) begin
            nib = (value >> (4 * i)) & 4'hf;
            if (nib < 10) ch = 8'("0" + nib);
            else ch = 8'(($urandom_range(0, 1) ? "a" : "A") + nib - 10);
            send_byte(ch, 1'b0);
            if ($urandom_range(0, 7) == 0)
                send_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB, 1'b0);
        end
        if ($urandom_range(0, 2) == 0) begin
            send_byte(CH_SEMI, 1'b0);
            repeat ($urandom_range(0, 6)) begin
                ch = 8'($urandom_range(0, 255));
                if (ch == CH_CR) begin
                    // lone CR: the next byte must not close the line
                    send_byte(CH_CR, 1'b0);
                    ch = 8'($urandom_range(0, 255));
                    if (ch == CH_LF || ch == CH_CR) ch = "x";
                end
                send_byte(ch, 1'b0);
            end
        end
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, 1'b0);
    endtask

    task automatic send_chunk(input int unsigned size, input logic last_on_lf);
        send_size_line(size);
        repeat (size) send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_byte(CH_CR, 1'b0);
        send_byte(CH_LF, last_on_lf);
    endtask

    task automatic run_body(input int count);
        int          start;
        int unsigned cap;
        start = accepted_bytes;
        while (accepted_bytes - start < count) begin
            cap = (board.limit < 24) ? board.limit : 24;
            if ($urandom_range(0, 15) == 0 && board.limit >= 200) cap = 200;
            send_chunk($urandom_range(1, cap), 1'b0);
        end
    endtask

    task automatic finish_body(input ending_t ending);
        logic [7:0]  ch;
        int unsigned n;
        int unsigned lim;
        case (ending)
            END_ZERO_CHUNK: begin
                send_size_line(0);
                // trailers after the last chunk are ignored
                send_text("X-Check: ok\r\n\r");
                send_byte(CH_LF, 1'b1);
            end
            END_EMPTY_LINE: begin
                if ($urandom_range(0, 1)) send_byte(CH_SPACE, 1'b0);
                send_text("\r\n");
            end
            END_FINAL_ON_LF: send_chunk($urandom_range(1, 16), 1'b1);
            END_TRUNCATED: begin
                n = $urandom_range(2, 12);
                send_size_line(n);
                repeat ($urandom_range(0, n - 1))
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                send_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            END_BAD_HEX: begin
                if ($urandom_range(0, 1)) send_byte("1", 1'b0);
                do ch = 8'($urandom_range(0, 255));
                while ((ch >= "0" && ch <= "9") || (ch >= "a" && ch <= "f") ||
                       (ch >= "A" && ch <= "F") || ch == CH_CR || ch == CH_SEMI ||
                       ch == CH_SPACE || ch == CH_TAB);
                send_byte(ch, 1'b0);
            end
            END_OVER_LIMIT: begin
                drain();
                lim = $urandom_range(0, 1) ? LIMIT_RESET : $urandom_range(1, 4095);
                write_limit(LIMIT_W'(lim));
                send_size_line(lim + 1);
            end
            END_NO_CRLF: begin
                n = $urandom_range(1, 8);
                send_size_line(n);
                repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
                if ($urandom_range(0, 1)) send_byte(CH_CR, 1'b0);
                do ch = 8'($urandom_range(0, 255)); while (ch == CH_CR || ch == CH_LF);
                send_byte(ch, 1'b0);
            end
            END_LONE_CR: begin
                send_text("3\r");
                do ch = 8'($urandom_range(0, 255)); while (ch == CH_LF);
                send_byte(ch, 1'b0);
            end
            END_FINAL_IN_LINE: begin
                send_byte("5", 1'b0);
                send_byte(CH_CR, 1'b1);
            end
            default: begin
                drain();
                write_limit('0);
                send_size_line($urandom_range(1, 15));
            end
        endcase
    endtask

    initial begin
        int phase_no;
        board          = new();
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        m_tready       = 1'b0;
        gap_pct        = 0;
        stall_pct      = 0;
        accepted_bytes = 0;
        cycle_count    = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // blanks, extension with a lone CR, payload extremes, CR CR LF in an extension
        send_text(" 1\t;x\rq\r\n");
        send_byte(8'h00, 1'b0);
        send_text("\r\n0a;\r\r\n");
        send_byte(8'hff, 1'b0);
        repeat (9) send_byte(8'($urandom_range(0, 255)), 1'b0);
        send_text("\r\n");

        for (phase_no = 0; phase_no < 4; phase_no++) begin
            drain();
            case (phase_no)
                0: begin
                    gap_pct = 0;  stall_pct = 0;
                    write_limit(LIMIT_RESET);
                end
                1: begin
                    gap_pct = 84; stall_pct = 0;
                    write_limit(LIMIT_W'(1));
                end
                2: begin
                    gap_pct = 0;  stall_pct = 84;
                    write_limit(LIMIT_W'($urandom_range(2, 300)));
                end
                default: begin
                    gap_pct = 28; stall_pct = 28;
                    write_limit(LIMIT_W'($urandom_range(1, LIMIT_RESET)));
                end
            endcase
            run_body(490);
        end

        drain();
        gap_pct   = $urandom_range(0, 1) ? 0 : 84;
        stall_pct = $urandom_range(0, 1) ? 0 : 84;
        run_body(30);
        finish_body(ending_t'($urandom_range(0, 9)));
        // bytes after the body has ended must be dropped with the status held
        repeat (16) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        drain();
        repeat (4) @(posedge aclk);

        if (board.mismatches == 0 && board.expected_results.size() == 0) begin
            $display("PASS http_chunked_body_decoder_top");
        end else begin
            $display("FAIL http_chunked_body_decoder_top");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/chd_pkg.sv
rtl/chd_parser.sv
rtl/http_chunked_body_decoder_top.sv
sim/tb_http_chunked_body_decoder_top.sv
